// ===== src/i2crts_pkg.sv =====
// Shared types and codes for the I2C register transaction sequencer.
`default_nettype none
package i2crts_pkg;

    // Item kinds
    localparam logic [2:0] KIND_WRITE8    = 3'd0;
    localparam logic [2:0] KIND_READ8     = 3'd1;
    localparam logic [2:0] KIND_READ16    = 3'd2;
    localparam logic [2:0] KIND_READ16R   = 3'd3;
    localparam logic [2:0] KIND_COND_DONE = 3'd4;
    localparam logic [2:0] KIND_BYTE_SENT = 3'd5;
    localparam logic [2:0] KIND_BYTE_RCVD = 3'd6;

    // Bus engine commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_RESTART = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_SEND    = 3'd4;
    localparam logic [2:0] CMD_RECV    = 3'd5;
    localparam logic [2:0] CMD_ACK     = 3'd6;

    // Transaction operations
    localparam logic [1:0] OP_WRITE8  = 2'd0;
    localparam logic [1:0] OP_READ8   = 2'd1;
    localparam logic [1:0] OP_READ16  = 2'd2;
    localparam logic [1:0] OP_READ16R = 2'd3;

    // Sequencer phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_START   = 4'd1;
    localparam logic [3:0] PH_WADDR   = 4'd2;
    localparam logic [3:0] PH_REG     = 4'd3;
    localparam logic [3:0] PH_DATA    = 4'd4;
    localparam logic [3:0] PH_RESTART = 4'd5;
    localparam logic [3:0] PH_RADDR   = 4'd6;
    localparam logic [3:0] PH_RXMSB   = 4'd7;
    localparam logic [3:0] PH_ACK     = 4'd8;
    localparam logic [3:0] PH_RXLSB   = 4'd9;
    localparam logic [3:0] PH_STOP    = 4'd10;

    localparam logic READ_BIT = 1'b1;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] target_id;
        logic [7:0] reg_sel;
        logic [7:0] write_value;
        logic [7:0] retry_limit;
        logic       nack;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  bus_cmd;
        logic [7:0]  tx_byte;
        logic        done_res;
        logic        status;
        logic [15:0] read_value;
        logic        busy_res;
    } result_t;

endpackage
`default_nettype wire

// ===== src/i2crts_core.sv =====
// Transaction state machine: holds the sequencer state and decodes one item.
`default_nettype none
module i2crts_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire i2crts_pkg::item_t   item,
    output i2crts_pkg::result_t      result
);
    import i2crts_pkg::*;

    logic [3:0] phase_reg, phase_next;
    logic [1:0] op_reg, op_next;
    logic [6:0] taddr_reg, taddr_next;
    logic [7:0] rindex_reg, rindex_next;
    logic [7:0] wdata_reg, wdata_next;
    logic [7:0] bound_reg, bound_next;
    logic [8:0] rcount_reg, rcount_next;
    logic [7:0] hbyte_reg, hbyte_next;
    logic [7:0] lbyte_reg, lbyte_next;
    logic       err_reg, err_next;

    always_comb begin
        phase_next  = phase_reg;
        op_next     = op_reg;
        taddr_next  = taddr_reg;
        rindex_next = rindex_reg;
        wdata_next  = wdata_reg;
        bound_next  = bound_reg;
        rcount_next = rcount_reg;
        hbyte_next  = hbyte_reg;
        lbyte_next  = lbyte_reg;
        err_next    = err_reg;
        result      = '0;

        case (item.kind)
            KIND_WRITE8, KIND_READ8, KIND_READ16, KIND_READ16R: begin
                // requests while busy are dropped
                if (phase_reg == PH_IDLE) begin
                    op_next        = item.kind[1:0];
                    taddr_next     = item.target_id;
                    rindex_next    = item.reg_sel;
                    wdata_next     = item.write_value;
                    bound_next     = item.retry_limit;
                    rcount_next    = '0;
                    hbyte_next     = '0;
                    lbyte_next     = '0;
                    err_next       = 1'b0;
                    result.bus_cmd = CMD_START;
                    phase_next     = PH_START;
                end
            end
            KIND_COND_DONE: begin
                case (phase_reg)
                    PH_START: begin
                        result.bus_cmd = CMD_SEND;
                        result.tx_byte = {taddr_reg, 1'b0};
                        phase_next     = PH_WADDR;
                    end
                    PH_RESTART: begin
                        result.bus_cmd = CMD_SEND;
                        result.tx_byte = {taddr_reg, READ_BIT};
                        phase_next     = PH_RADDR;
                    end
                    PH_ACK: begin
                        result.bus_cmd = CMD_RECV;
                        phase_next     = PH_RXLSB;
                    end
                    PH_STOP: begin
                        result.done_res   = 1'b1;
                        result.status     = err_reg;
                        result.read_value = err_reg ? 16'd0 : {hbyte_reg, lbyte_reg};
                        phase_next        = PH_IDLE;
                    end
                    default: ;
                endcase
            end
            KIND_BYTE_SENT: begin
                case (phase_reg)
                    PH_WADDR: begin
                        if (item.nack) begin
                            err_next       = 1'b1;
                            result.bus_cmd = CMD_STOP;
                            phase_next     = PH_STOP;
                        end else begin
                            result.bus_cmd = CMD_SEND;
                            result.tx_byte = rindex_reg;
                            phase_next     = PH_REG;
                        end
                    end
                    PH_REG: begin
                        if (item.nack) begin
                            err_next       = 1'b1;
                            result.bus_cmd = CMD_STOP;
                            phase_next     = PH_STOP;
                        end else if (op_reg == OP_WRITE8) begin
                            result.bus_cmd = CMD_SEND;
                            result.tx_byte = wdata_reg;
                            phase_next     = PH_DATA;
                        end else begin
                            result.bus_cmd = CMD_RESTART;
                            phase_next     = PH_RESTART;
                        end
                    end
                    PH_DATA: begin
                        if (item.nack) begin
                            err_next = 1'b1;
                        end
                        result.bus_cmd = CMD_STOP;
                        phase_next     = PH_STOP;
                    end
                    PH_RADDR: begin
                        if (!item.nack) begin
                            result.bus_cmd = CMD_RECV;
                            phase_next     = PH_RXMSB;
                        end else if (op_reg == OP_READ16R &&
                                     rcount_reg <= {1'b0, bound_reg}) begin
                            rcount_next    = rcount_reg + 9'd1;
                            result.bus_cmd = CMD_RESTART;
                            phase_next     = PH_RESTART;
                        end else begin
                            err_next       = 1'b1;
                            result.bus_cmd = CMD_STOP;
                            phase_next     = PH_STOP;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_BYTE_RCVD: begin
                case (phase_reg)
                    PH_RXMSB: begin
                        if (op_reg == OP_READ8) begin
                            hbyte_next     = '0;
                            lbyte_next     = item.rx_byte;
                            result.bus_cmd = CMD_STOP;
                            phase_next     = PH_STOP;
                        end else begin
                            hbyte_next     = item.rx_byte;
                            result.bus_cmd = CMD_ACK;
                            phase_next     = PH_ACK;
                        end
                    end
                    PH_RXLSB: begin
                        lbyte_next     = item.rx_byte;
                        result.bus_cmd = CMD_STOP;
                        phase_next     = PH_STOP;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        result.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            op_reg     <= '0;
            taddr_reg  <= '0;
            rindex_reg <= '0;
            wdata_reg  <= '0;
            bound_reg  <= '0;
            rcount_reg <= '0;
            hbyte_reg  <= '0;
            lbyte_reg  <= '0;
            err_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            op_reg     <= op_next;
            taddr_reg  <= taddr_next;
            rindex_reg <= rindex_next;
            wdata_reg  <= wdata_next;
            bound_reg  <= bound_next;
            rcount_reg <= rcount_next;
            hbyte_reg  <= hbyte_next;
            lbyte_reg  <= lbyte_next;
            err_reg    <= err_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/i2c_register_transaction_sequencer_top.sv =====
// I2C register transaction sequencer: stream wrapper with input and result registers.
//
// Usage: requests (write8, read8, read16, read16 with retry) and bus engine
// events (condition done, byte sent, byte received) arrive as items on the
// s_ channel, kind in s_tuser. Every item yields exactly one result item on
// the m_ channel: the next bus command in m_tuser, plus tx byte, done, status,
// read value and busy in m_tdata.
// Path: an item is registered at the input, decoded against the sequencer
// state when it moves on, and its result lands in the result register,
// from which it shows on the m_ channel.
// Throughput: one item per cycle while m_tready stays high; the state machine
// update is a single registered step per item.
// Reset (aresetn low, synchronous): both stages empty, sequencer idle with
// all transaction state cleared.
// Stall: while m_tready is low the result register holds; the input register
// still takes one more item, then s_tready drops until the result is taken.
`default_nettype none
module i2c_register_transaction_sequencer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // target_id[6:0], reg_sel[14:7], write_value[22:15], retry_limit[30:23],
    // nack[31], rx_byte[39:32]
    input  wire logic [39:0] s_tdata,
    // kind[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tx_byte[7:0], done_res[8], status[9], read_value[25:10], busy_res[26], zero[31:27]
    output logic [31:0]      m_tdata,
    // bus_cmd[2:0]
    output logic [2:0]       m_tuser
);
    import i2crts_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;

    // the held item moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.kind        <= s_tuser;
            in_item_reg.target_id   <= s_tdata[6:0];
            in_item_reg.reg_sel     <= s_tdata[14:7];
            in_item_reg.write_value <= s_tdata[22:15];
            in_item_reg.retry_limit <= s_tdata[30:23];
            in_item_reg.nack        <= s_tdata[31];
            in_item_reg.rx_byte     <= s_tdata[39:32];
        end
    end

    i2crts_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.bus_cmd;
    assign m_tdata  = {5'd0, out_res_reg.busy_res, out_res_reg.read_value,
                       out_res_reg.status, out_res_reg.done_res, out_res_reg.tx_byte};

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the I2C register transaction sequencer.
`default_nettype none
module tb_top;
    import i2crts_pkg::*;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 900;

    // Tracks the sequencer state and holds the bus actions still owed by the block.
    class txn_scoreboard;
        logic [3:0] phase;
        logic [1:0] op;
        logic [6:0] target;
        logic [7:0] reg_idx;
        logic [7:0] wdata;
        logic [7:0] bound;
        logic [8:0] retries;
        logic [7:0] msb;
        logic [7:0] lsb;
        logic       err;
        result_t    expected_actions[$];
        int         errors;

        function new();
            phase = PH_IDLE;
            op = OP_WRITE8;
            target = '0;
            reg_idx = '0;
            wdata = '0;
            bound = '0;
            retries = '0;
            msb = '0;
            lsb = '0;
            err = 1'b0;
            errors = 0;
        endfunction

        function result_t stop_on_nack();
            result_t r;
            r = '0;
            err = 1'b1;
            r.bus_cmd = CMD_STOP;
            phase = PH_STOP;
            return r;
        endfunction

        function result_t next_bus_action(item_t it);
            result_t r;
            r = '0;
            case (it.kind)
                KIND_WRITE8, KIND_READ8, KIND_READ16, KIND_READ16R: begin
                    // requests are dropped while a transaction runs
                    if (phase == PH_IDLE) begin
                        op = it.kind[1:0];
                        target = it.target_id;
                        reg_idx = it.reg_sel;
                        wdata = it.write_value;
                        bound = it.retry_limit;
                        retries = '0;
                        msb = '0;
                        lsb = '0;
                        err = 1'b0;
                        r.bus_cmd = CMD_START;
                        phase = PH_START;
                    end
                end
                KIND_COND_DONE: begin
                    case (phase)
                        PH_START: begin
                            r.bus_cmd = CMD_SEND;
                            r.tx_byte = {target, 1'b0};
                            phase = PH_WADDR;
                        end
                        PH_RESTART: begin
                            r.bus_cmd = CMD_SEND;
                            r.tx_byte = {target, READ_BIT};
                            phase = PH_RADDR;
                        end
                        PH_ACK: begin
                            r.bus_cmd = CMD_RECV;
                            phase = PH_RXLSB;
                        end
                        PH_STOP: begin
                            r.done_res = 1'b1;
                            r.status = err;
                            r.read_value = err ? 16'h0000 : {msb, lsb};
                            phase = PH_IDLE;
                        end
                        default: ;
                    endcase
                end
                KIND_BYTE_SENT: begin
                    case (phase)
                        PH_WADDR: begin
                            if (it.nack) begin
                                r = stop_on_nack();
                            end else begin
                                r.bus_cmd = CMD_SEND;
                                r.tx_byte = reg_idx;
                                phase = PH_REG;
                            end
                        end
                        PH_REG: begin
                            if (it.nack) begin
                                r = stop_on_nack();
                            end else if (op == OP_WRITE8) begin
                                r.bus_cmd = CMD_SEND;
                                r.tx_byte = wdata;
                                phase = PH_DATA;
                            end else begin
                                r.bus_cmd = CMD_RESTART;
                                phase = PH_RESTART;
                            end
                        end
                        PH_DATA: begin
                            if (it.nack) begin
                                r = stop_on_nack();
                            end else begin
                                r.bus_cmd = CMD_STOP;
                                phase = PH_STOP;
                            end
                        end
                        PH_RADDR: begin
                            if (!it.nack) begin
                                r.bus_cmd = CMD_RECV;
                                phase = PH_RXMSB;
                            end else if (op == OP_READ16R && retries <= {1'b0, bound}) begin
                                retries = retries + 9'd1;
                                r.bus_cmd = CMD_RESTART;
                                phase = PH_RESTART;
                            end else begin
                                r = stop_on_nack();
                            end
                        end
                        default: ;
                    endcase
                end
                KIND_BYTE_RCVD: begin
                    if (phase == PH_RXMSB) begin
                        if (op == OP_READ8) begin
                            msb = '0;
                            lsb = it.rx_byte;
                            r.bus_cmd = CMD_STOP;
                            phase = PH_STOP;
                        end else begin
                            msb = it.rx_byte;
                            r.bus_cmd = CMD_ACK;
                            phase = PH_ACK;
                        end
                    end else if (phase == PH_RXLSB) begin
                        lsb = it.rx_byte;
                        r.bus_cmd = CMD_STOP;
                        phase = PH_STOP;
                    end
                end
                default: ;
            endcase
            r.busy_res = (phase != PH_IDLE);
            return r;
        endfunction

        function void note_item(item_t it);
            expected_actions.push_back(next_bus_action(it));
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_actions.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            exp = expected_actions.pop_front();
            compare_field("bus_cmd", 32'(exp.bus_cmd), 32'(got.bus_cmd));
            compare_field("tx_byte", 32'(exp.tx_byte), 32'(got.tx_byte));
            compare_field("done_res", 32'(exp.done_res), 32'(got.done_res));
            compare_field("status", 32'(exp.status), 32'(got.status));
            compare_field("read_value", 32'(exp.read_value), 32'(got.read_value));
            compare_field("busy_res", 32'(exp.busy_res), 32'(got.busy_res));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    int gap_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    txn_scoreboard sb = new();

    i2c_register_transaction_sequencer_top uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9],
                             m_tdata[25:10], m_tdata[26]});
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_item(input item_t it);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {it.rx_byte, it.nack, it.retry_limit, it.write_value,
                    it.reg_sel, it.target_id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(it);
    endtask

    task automatic send(input logic [2:0] kind, input logic [6:0] dev, input logic [7:0] regs,
                        input logic [7:0] wval, input logic [7:0] lim, input logic nk,
                        input logic [7:0] rx);
        item_t it;
        it.kind = kind;
        it.target_id = dev;
        it.reg_sel = regs;
        it.write_value = wval;
        it.retry_limit = lim;
        it.nack = nk;
        it.rx_byte = rx;
        push_item(it);
    endtask

    // Mostly the event the engine would really report next, with random payload.
    function automatic item_t make_item();
        item_t it;
        it.target_id = 7'($urandom);
        it.reg_sel = 8'($urandom);
        it.write_value = 8'($urandom);
        it.retry_limit = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        it.nack = 1'($urandom);
        it.rx_byte = 8'($urandom);
        if ($urandom_range(99) < 12) begin
            it.kind = 3'($urandom);
        end else begin
            case (sb.phase)
                PH_IDLE: it.kind = 3'($urandom_range(3));
                PH_START, PH_RESTART, PH_ACK, PH_STOP: it.kind = KIND_COND_DONE;
                PH_RXMSB, PH_RXLSB: it.kind = KIND_BYTE_RCVD;
                default: begin
                    it.kind = KIND_BYTE_SENT;
                    if (sb.phase == PH_RADDR && sb.op == OP_READ16R)
                        it.nack = ($urandom_range(2) != 0);
                    else
                        it.nack = ($urandom_range(11) == 0);
                end
            endcase
        end
        return it;
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct = 12;
        stall_pct = 83;

        // events and an unused kind while idle
        send(KIND_COND_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_BYTE_SENT, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff);
        send(KIND_BYTE_RCVD, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'hff);
        send(KIND_UNUSED, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff);
        // full write, with a request arriving mid-transaction
        send(KIND_WRITE8, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00);
        send(KIND_READ16, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_COND_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        send(KIND_BYTE_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_BYTE_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_BYTE_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_COND_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        // read8 with an out-of-order event, then a NACKed address
        send(KIND_READ8, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_COND_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_BYTE_RCVD, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h5a);
        send(KIND_BYTE_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        send(KIND_COND_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        // retry read with bound zero: one retry, then error
        send(KIND_READ16R, 7'h55, 8'haa, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_COND_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_BYTE_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_BYTE_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_COND_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_BYTE_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        send(KIND_COND_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        send(KIND_BYTE_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        send(KIND_COND_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                gap_pct = 83;
                stall_pct = 12;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                gap_pct = 0;
                stall_pct = 0;
            end
            push_item(make_item());
        end
        s_tvalid <= 1'b0;

        while (sb.expected_actions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.expected_actions.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
